// ===== rtl/agbkf_pkg.sv =====
// Package: shared types, constants and fixed-point helpers for the angle Kalman filter.
`timescale 1ns / 1ps
package agbkf_pkg;

	localparam int unsigned QW = 32;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_NOISE = 2'd0,
		REG_BIAS_NOISE  = 2'd1,
		REG_MEAS_NOISE  = 2'd2,
		REG_TIME_STEP   = 2'd3
	} cfg_reg_t;

	localparam logic [15:0] ANGLE_NOISE_RST = 16'd131;
	localparam logic [15:0] BIAS_NOISE_RST  = 16'd131;
	localparam logic [23:0] MEAS_NOISE_RST  = 24'd32768;
	localparam logic [15:0] TIME_STEP_RST   = 16'd655;
	localparam logic signed [31:0] Q_ONE    = 32'sd65536;

	// Micro-operations issued by the sequencer to the datapath.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_MUL,     // acc = floor(a*b >> 16), saturated
		OP_ADD,     // acc = sat(a + b)
		OP_SUB,     // acc = sat(a - b), unsaturated difference kept as well
		OP_SUBW,    // acc = sat(kept unsaturated difference - b)
		OP_DIV      // start divider: gain = sat(a*65536 / den)
	} op_t;

	// Operand / destination register file addresses.
	typedef enum logic [3:0] {
		R_ANG, R_BIAS, R_P00, R_P01, R_P10, R_P11,
		R_MEAS, R_GYRO, R_RATE, R_T0, R_T1, R_G0, R_G1, R_ERR,
		R_DT, R_QA
	} reg_t;

	typedef struct packed {
		op_t  op;
		reg_t src_a;
		reg_t src_b;
		reg_t dst;
		logic ld_in;    // latch input sample
		logic ld_out;   // latch result registers
		logic sel_qg;   // operand b replaced by bias noise
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) r = 32'sh7fffffff;
		else if (v < -66'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/agbkf_div.sv =====
// Restoring divider: quotient of (num*65536)/den, truncated toward zero, saturated.
`timescale 1ns / 1ps
module agbkf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  num,
	input  logic signed [33:0]  den,
	output logic                busy,
	output logic                done,
	output logic signed [31:0]  quo
);
	import agbkf_pkg::*;

	localparam int unsigned NW = 48;

	logic [NW-1:0] rem_q;
	logic [NW-1:0] q_q;
	logic [NW-1:0] n_q;
	logic [32:0]   d_q;
	logic          neg_q;
	logic          zero_q;
	logic [5:0]    cnt_q;
	logic [NW:0]   trial;
	logic [NW-1:0] rem_sh;
	logic signed [65:0] sq;

	assign rem_sh = {rem_q[NW-2:0], n_q[NW-1]};
	assign trial  = {1'b0, rem_sh} - {{(NW-33+1){1'b0}}, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy   <= 1'b1;
				cnt_q  <= 6'(NW);
				rem_q  <= '0;
				q_q    <= '0;
				n_q    <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
				d_q    <= den[33] ? 33'(-den) : 33'(den);
				neg_q  <= num[31] ^ den[33];
				zero_q <= (den == '0);
			end else if (busy) begin
				n_q <= {n_q[NW-2:0], 1'b0};
				if (!trial[NW]) begin
					rem_q <= trial[NW-1:0];
					q_q   <= {q_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					q_q   <= {q_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign sq  = neg_q ? -$signed({18'd0, q_q}) : $signed({18'd0, q_q});
	assign quo = zero_q ? 32'sd0 : sat32(sq);

	div_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("divider done while busy");
	div_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy) else $error("divider did not start");
endmodule

// ===== rtl/agbkf_datapath.sv =====
// Datapath: register file, multiplier, adder and divider of the filter.
`timescale 1ns / 1ps
module agbkf_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  agbkf_pkg::cmd_t       cmd,
	output agbkf_pkg::stat_t      stat,
	input  logic signed [31:0]    accel_angle,
	input  logic signed [31:0]    gyro_rate,
	input  logic [15:0]           qa,
	input  logic [15:0]           qg,
	input  logic [23:0]           rn,
	input  logic [15:0]           dt,
	output logic signed [31:0]    filtered_angle,
	output logic signed [31:0]    filtered_rate
);
	import agbkf_pkg::*;

	logic signed [31:0] rf_q [16];
	logic signed [31:0] a, b, res;
	logic signed [63:0] prod;
	logic signed [65:0] sum;
	logic signed [33:0] raw_q;   // last difference before saturation
	logic signed [31:0] quo;
	logic               dbusy, ddone;

	always_comb begin
		a = rf_q[cmd.src_a];
		b = cmd.sel_qg ? $signed({16'd0, qg}) : rf_q[cmd.src_b];
		if (cmd.src_a == R_DT) a = $signed({16'd0, dt});
		if (cmd.src_a == R_QA) a = $signed({16'd0, qa});
		if (!cmd.sel_qg && cmd.src_b == R_DT) b = $signed({16'd0, dt});
	end

	assign prod = a * b;
	always_comb begin
		unique case (cmd.op)
			OP_MUL:  sum = 66'(prod >>> 16);
			OP_ADD:  sum = 66'(a) + 66'(b);
			OP_SUB:  sum = 66'(a) - 66'(b);
			OP_SUBW: sum = 66'(raw_q) - 66'(b);
			default: sum = '0;
		endcase
	end
	assign res = sat32(sum);

	agbkf_div u_div (
		.clk(clk), .arst_n(arst_n),
		.start(cmd.op == OP_DIV),
		.num(a),
		.den(34'($signed({1'b0, rn})) + 34'(rf_q[R_P00])),
		.busy(dbusy), .done(ddone), .quo(quo)
	);
	assign stat = '{div_busy: dbusy, div_done: ddone};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q[R_ANG]  <= '0;
			rf_q[R_BIAS] <= '0;
			rf_q[R_P00]  <= Q_ONE;
			rf_q[R_P01]  <= '0;
			rf_q[R_P10]  <= '0;
			rf_q[R_P11]  <= Q_ONE;
			raw_q        <= '0;
		end else begin
			if (cmd.ld_in) begin
				rf_q[R_MEAS] <= accel_angle;
				rf_q[R_GYRO] <= gyro_rate;
			end
			if (cmd.op == OP_SUB)
				raw_q <= sum[33:0];
			if (cmd.op == OP_MUL || cmd.op == OP_ADD || cmd.op == OP_SUB ||
					cmd.op == OP_SUBW)
				rf_q[cmd.dst] <= res;
			if (ddone)
				rf_q[cmd.dst] <= quo;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			filtered_angle <= rf_q[R_ANG];
			filtered_rate  <= rf_q[R_RATE];
		end
	end
endmodule

// ===== rtl/agbkf_ctrl.sv =====
// Controller: micro-program sequencer and handshakes.
`timescale 1ns / 1ps
module agbkf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output agbkf_pkg::cmd_t  cmd,
	input  agbkf_pkg::stat_t stat
);
	import agbkf_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV} state_t;

	localparam int unsigned NSTEP = 22;

	state_t     state_q;
	logic [4:0] pc_q;
	cmd_t       uc;

	function automatic cmd_t mk(op_t o, reg_t sa, reg_t sb, reg_t d);
		cmd_t c;
		c = '{op: o, src_a: sa, src_b: sb, dst: d,
			ld_in: 1'b0, ld_out: 1'b0, sel_qg: 1'b0};
		return c;
	endfunction

	// Micro-program: one step of the filter per entry.
	always_comb begin
		unique case (pc_q)
			5'd0:  uc = mk(OP_SUB, R_GYRO, R_BIAS, R_RATE);
			5'd1:  uc = mk(OP_MUL, R_RATE, R_DT, R_T0);
			5'd2:  uc = mk(OP_ADD, R_ANG, R_T0, R_ANG);
			5'd3:  uc = mk(OP_SUB, R_QA, R_P01, R_T0);
			// Qa - P01 - P10 saturates once, so take the unsaturated difference.
			5'd4:  uc = mk(OP_SUBW, R_T0, R_P10, R_T0);
			5'd5:  uc = mk(OP_MUL, R_T0, R_DT, R_T0);
			5'd6:  uc = mk(OP_ADD, R_P00, R_T0, R_P00);
			5'd7:  uc = mk(OP_MUL, R_P11, R_DT, R_T1);
			5'd8:  uc = mk(OP_SUB, R_P01, R_T1, R_P01);
			5'd9:  uc = mk(OP_SUB, R_P10, R_T1, R_P10);
			5'd10: begin
				uc = mk(OP_MUL, R_DT, R_DT, R_T1);
				uc.sel_qg = 1'b1;
			end
			5'd11: uc = mk(OP_ADD, R_P11, R_T1, R_P11);
			5'd12: uc = mk(OP_SUB, R_MEAS, R_ANG, R_ERR);
			5'd13: uc = mk(OP_DIV, R_P00, R_P00, R_G0);
			5'd14: uc = mk(OP_DIV, R_P10, R_P10, R_G1);
			5'd15: uc = mk(OP_MUL, R_G1, R_P00, R_T0);
			5'd16: uc = mk(OP_SUB, R_P10, R_T0, R_P10);
			5'd17: uc = mk(OP_MUL, R_G1, R_P01, R_T0);
			5'd18: uc = mk(OP_SUB, R_P11, R_T0, R_P11);
			5'd19: uc = mk(OP_MUL, R_G0, R_P01, R_T0);
			5'd20: uc = mk(OP_SUB, R_P01, R_T0, R_P01);
			default: uc = mk(OP_NOP, R_ANG, R_ANG, R_ANG);
		endcase
	end

	// Tail steps after the gains: need old P00 for G1*P00 and G0*P00, so
	// G0*P00 is done last; a second tail bank below.
	logic [3:0] tpc_q;
	cmd_t       tc;
	always_comb begin
		unique case (tpc_q)
			4'd0: tc = mk(OP_MUL, R_G0, R_P00, R_T0);
			4'd1: tc = mk(OP_SUB, R_P00, R_T0, R_P00);
			4'd2: tc = mk(OP_MUL, R_G0, R_ERR, R_T0);
			4'd3: tc = mk(OP_ADD, R_ANG, R_T0, R_ANG);
			4'd4: tc = mk(OP_MUL, R_G1, R_ERR, R_T0);
			4'd5: tc = mk(OP_ADD, R_BIAS, R_T0, R_BIAS);
			4'd6: tc = mk(OP_SUB, R_GYRO, R_BIAS, R_RATE);
			default: tc = mk(OP_NOP, R_ANG, R_ANG, R_ANG);
		endcase
	end

	logic tail_q;
	logic div_wait_q;

	always_comb begin
		cmd = tail_q ? tc : uc;
		if (state_q == S_IDLE) cmd = mk(OP_NOP, R_ANG, R_ANG, R_ANG);
		if (state_q == S_DIV) begin
			cmd = uc;
			cmd.op = OP_NOP;
		end
		cmd.ld_in  = (state_q == S_IDLE) && in_valid && in_ready;
		cmd.ld_out = tail_q && tpc_q == 4'd7;
	end

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= '0;
			tpc_q      <= '0;
			tail_q     <= 1'b0;
			out_valid  <= 1'b0;
			div_wait_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					state_q <= S_RUN;
					pc_q    <= '0;
					tpc_q   <= '0;
					tail_q  <= 1'b0;
				end
				S_RUN: begin
					if (tail_q) begin
						tpc_q <= tpc_q + 4'd1;
						if (tpc_q == 4'd7) begin
							out_valid <= 1'b1;
							state_q   <= S_IDLE;
						end
					end else if (uc.op == OP_DIV) begin
						state_q <= S_DIV;
					end else if (pc_q == 5'(NSTEP - 1)) begin
						tail_q <= 1'b1;
					end else begin
						pc_q <= pc_q + 5'd1;
					end
				end
				S_DIV: if (stat.div_done) begin
					state_q <= S_RUN;
					pc_q    <= pc_q + 5'd1;
				end
				default: state_q <= S_IDLE;
			endcase
			div_wait_q <= (state_q == S_DIV);
		end
	end

	ctl_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("input taken while busy");
	ctl_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	ctl_div_seen: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> div_wait_q) else $error("stray divider done");
	ctl_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && !stat.div_done |-> stat.div_busy)
		else $error("divider idle while waited on");
endmodule

// ===== rtl/angle_gyro_bias_kalman_filter.sv =====
// Top level: two-state angle / gyro-bias Kalman filter with config registers.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | in_valid / in_ready       | accel_angle, gyro_rate
//  output   | out_valid / out_ready     | filtered_angle, filtered_rate
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Each sample runs through the two 48-step serial divisions for the gains plus
// the micro-steps of the main and tail programs.
// Reset restores the register defaults, zero estimates and identity covariance.
// A new sample is taken once the last result transfer has completed.
// Config writes are always taken.
`timescale 1ns / 1ps
module angle_gyro_bias_kalman_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] accel_angle,
	input  logic signed [31:0] gyro_rate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] filtered_angle,
	output logic signed [31:0] filtered_rate,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import agbkf_pkg::*;

	logic [15:0] qa_q, qg_q, dt_q;
	logic [23:0] rn_q;
	cmd_t        cmd;
	stat_t       stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= ANGLE_NOISE_RST;
			qg_q <= BIAS_NOISE_RST;
			rn_q <= MEAS_NOISE_RST;
			dt_q <= TIME_STEP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ANGLE_NOISE: qa_q <= cfg_data[15:0];
				REG_BIAS_NOISE:  qg_q <= cfg_data[15:0];
				REG_MEAS_NOISE:  rn_q <= cfg_data;
				REG_TIME_STEP:   dt_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	agbkf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .stat(stat)
	);

	agbkf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.accel_angle(accel_angle), .gyro_rate(gyro_rate),
		.qa(qa_q), .qg(qg_q), .rn(rn_q), .dt(dt_q),
		.filtered_angle(filtered_angle), .filtered_rate(filtered_rate)
	);
endmodule

// ===== dv/angle_gyro_bias_kalman_filter_test.sv =====
// Self-checking testbench for the two-state angle / gyro-bias Kalman filter.
`timescale 1ns / 1ps
module angle_gyro_bias_kalman_filter_test;
	import agbkf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] accel_angle = '0;
	logic signed [31:0] gyro_rate = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] filtered_rate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	angle_gyro_bias_kalman_filter dut (.*);

	always #5 clk = ~clk;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
	} sample_t;

	// Pending samples for the driver, expected fused outputs for the monitor.
	sample_t sample_q[$];
	sample_t fused_q[$];

	// Filter model state and register copies.
	logic [15:0] q_angle, q_bias, dt_q;
	logic [23:0] r_meas;
	logic signed [31:0] est_ang, est_bias, p00, p01, p10, p11;

	localparam int unsigned HOLD_AT  = 100;  // output transfer that starts the long stall
	localparam int unsigned HOLD_LEN = 600;

	int unsigned mismatches = 0;
	int unsigned transfers_in = 0, transfers_out = 0;
	int unsigned pushed = 0;
	int unsigned rx_hold = 0;   // long receiver stall, started and counted by the monitor

	function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Q16.16 product, floor rounding (arithmetic shift floors), saturated.
	function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b);
		return clamp(p >>> 16);
	endfunction

	function automatic logic signed [31:0] fadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clamp(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [31:0] fsub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clamp(66'(a) - 66'(b));
	endfunction

	// Gain: (num << 16) / den truncated toward zero; zero denominator gives zero.
	function automatic logic signed [31:0] gain(input logic signed [31:0] num,
			input logic signed [65:0] den);
		logic signed [65:0] n;
		if (den == 0) return '0;
		n = 66'(num) * 66'sd65536;
		return clamp(n / den);
	endfunction

	task automatic reset_model();
		q_angle = ANGLE_NOISE_RST; q_bias = BIAS_NOISE_RST;
		r_meas = MEAS_NOISE_RST; dt_q = TIME_STEP_RST;
		est_ang = '0; est_bias = '0;
		p00 = Q_ONE; p01 = '0; p10 = '0; p11 = Q_ONE;
	endtask

	// One filter iteration; returns the expected outputs.
	function automatic sample_t kalman_update(input sample_t s);
		logic signed [31:0] dt, rate, deriv, step11, err, g0, g1, h0, h1;
		logic signed [65:0] innov;
		sample_t r;
		dt = {16'd0, dt_q};
		rate = fsub(s.rate, est_bias);
		est_ang = fadd(est_ang, fmul(rate, dt));
		deriv = clamp(66'($signed({1'b0, q_angle})) - 66'(p01) - 66'(p10));
		step11 = fmul(p11, dt);
		p00 = fadd(p00, fmul(deriv, dt));
		p01 = fsub(p01, step11);
		p10 = fsub(p10, step11);
		p11 = fadd(p11, fmul({16'd0, q_bias}, dt));
		err = fsub(s.angle, est_ang);
		h0 = p00; h1 = p01;
		innov = 66'($signed({1'b0, r_meas})) + 66'(p00);
		g0 = gain(p00, innov);
		g1 = gain(p10, innov);
		p00 = fsub(p00, fmul(g0, h0));
		p01 = fsub(p01, fmul(g0, h1));
		p10 = fsub(p10, fmul(g1, h0));
		p11 = fsub(p11, fmul(g1, h1));
		est_ang = fadd(est_ang, fmul(g0, err));
		est_bias = fadd(est_bias, fmul(g1, err));
		r.angle = est_ang;
		r.rate = fsub(s.rate, est_bias);
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 8) << 16;
			3: return -($urandom_range(0, 8) << 16);
			4: return $signed($urandom_range(0, 20'hfffff)) - 32'sh80000;
			default: return $urandom;
		endcase
	endfunction

	// Driver: expectation is formed at the transfer, from the current registers.
	int unsigned tx_gap = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			fused_q.push_back(kalman_update({accel_angle, gyro_rate}));
			transfers_in++;
		end
		if (!(in_valid && !in_ready)) begin
			if (tx_gap != 0 || sample_q.size() == 0) begin
				in_valid <= 1'b0;
				if (tx_gap != 0) tx_gap <= tx_gap - 1;
			end else begin
				in_valid <= 1'b1;
				{accel_angle, gyro_rate} <= sample_q.pop_front();
				tx_gap <= $urandom_range(0, 9) * $urandom_range(0, 1);
			end
		end
	end

	// Monitor: compares each output transfer with the oldest expectation.
	int unsigned rx_gap = 0;
	always @(posedge clk) begin
		sample_t want;
		if (out_valid && out_ready) begin
			transfers_out++;
			if (fused_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output transfer at %0t", $realtime);
			end else begin
				want = fused_q.pop_front();
				if (want.angle !== filtered_angle || want.rate !== filtered_rate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: angle exp %h got %h, rate exp %h got %h",
							transfers_out, want.angle, filtered_angle, want.rate,
							filtered_rate);
				end
			end
			rx_gap <= $urandom_range(0, 9) * $urandom_range(0, 1);
			if (transfers_out == HOLD_AT) rx_hold <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			out_ready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap <= rx_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic cfg_write(input cfg_reg_t idx, input logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ANGLE_NOISE: q_angle = val[15:0];
			REG_BIAS_NOISE: q_bias = val[15:0];
			REG_MEAS_NOISE: r_meas = val;
			REG_TIME_STEP: dt_q = val[15:0];
		endcase
	endtask

	// Wait until every pushed sample has come back, then allow the block to settle.
	task automatic drain();
		while (transfers_out != pushed) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic push(input logic [31:0] a, input logic [31:0] g);
		sample_q.push_back({a, g});
		pushed++;
	endtask

	initial begin
		int n;
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: defaults, zeros, field extremes, saturation.
		push(0, 0); push(32'h7fffffff, 32'h7fffffff); push(32'h80000000, 32'h80000000);
		push(32'h7fffffff, 32'h80000000); push(32'h80000000, 32'h7fffffff);
		push(32'hffffffff, 32'h00000001); push(32'h00010000, 32'hffff0000);
		push(32'h55555555, 32'haaaaaaaa); push(32'haaaaaaaa, 32'h55555555);
		drain();
		// Zero measurement noise with a negative covariance: zero innovation possible.
		cfg_write(REG_MEAS_NOISE, 24'd0);
		cfg_write(REG_TIME_STEP, 24'hffff);
		cfg_write(REG_ANGLE_NOISE, 24'd0);
		cfg_write(REG_BIAS_NOISE, 24'hffff);
		for (int i = 0; i < 8; i++) push(rand_word(), rand_word());
		drain();
		cfg_write(REG_MEAS_NOISE, 24'hffffff);
		cfg_write(REG_TIME_STEP, 24'd1);
		cfg_write(REG_ANGLE_NOISE, 24'hffff);
		cfg_write(REG_BIAS_NOISE, 24'd0);
		for (int i = 0; i < 6; i++) push(rand_word(), rand_word());
		drain();

		// Random phases with fresh settings; the monitor stalls long during the first.
		for (int ph = 0; ph < 6; ph++) begin
			cfg_write(REG_ANGLE_NOISE, 24'($urandom_range(0, 16'hffff)));
			cfg_write(REG_BIAS_NOISE, 24'($urandom_range(0, 16'hffff)));
			cfg_write(REG_MEAS_NOISE,
				24'($urandom_range(0, 24'hffffff) >> $urandom_range(0, 20)));
			cfg_write(REG_TIME_STEP,
				24'($urandom_range(1, 16'hffff) >> $urandom_range(0, 12)));
			n = 200;
			for (int i = 0; i < n; i++) begin
				push(rand_word(), rand_word());
				// Sender pause until everything has come back.
				if (i == n / 2) while (transfers_out != pushed) @(posedge clk);
			end
			drain();
		end

		$display("covered %0d samples over nine register settings, incl. zero noise", transfers_in);
		$display("and full-range extremes, output stalls and sender pauses");
		if (mismatches == 0 && transfers_out == transfers_in) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/agbkf_pkg.sv
rtl/agbkf_div.sv
rtl/agbkf_datapath.sv
rtl/agbkf_ctrl.sv
rtl/angle_gyro_bias_kalman_filter.sv
dv/angle_gyro_bias_kalman_filter_test.sv
